FILE: rtl/cvlg_pkg.sv
// Shared types, codes and constants for the composite video line generator.
`default_nettype none
package cvlg_pkg;

    localparam int DEF_LINE_PIXELS = 32;
    localparam int DEF_FRAME_ROWS  = 64;

    localparam logic [8:0] LINE_WRAP      = 9'd318;
    localparam logic [8:0] ROW_RESET_LINE = 9'd23;
    localparam logic [8:0] VSYNC_ON_LINE  = 9'd312;
    localparam logic [8:0] VSYNC_OFF_LINE = 9'd316;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_COMPARE = 2'd2;

    localparam logic [2:0] REG_FIRST_DRAWN_LINE = 3'd0;
    localparam logic [2:0] REG_DISPLAY_ENABLE   = 3'd1;
    localparam logic [2:0] REG_BURST_ENABLE     = 3'd2;
    localparam logic [2:0] REG_BURST_LEVEL      = 3'd3;
    localparam logic [2:0] REG_WHITE_LEVEL      = 3'd4;
    localparam logic [2:0] REG_BLACK_LEVEL      = 3'd5;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] pixel_row;
        logic [4:0] pixel_col;
        logic [7:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic       sync_drive;
        logic [7:0] video_level;
        logic       video_update;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PIXELS,
        ST_WHITE,
        ST_BLACK
    } ctl_state_t;

    typedef enum logic [2:0] {
        RES_TICK,
        RES_PORCH,
        RES_PIXEL,
        RES_WHITE,
        RES_BLACK
    } res_kind_t;

    typedef struct packed {
        logic      write_pixel;
        logic      tick;
        logic      porch;
        logic      draw_start;
        logic      issue;
        res_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic advance;
        logic line_phase;
        logic draw_ok;
        logic col_last;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/cvlg_ctrl.sv
// Sequencer: decodes items and steps through the results of a line.
`default_nettype none
module cvlg_ctrl
    import cvlg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] operation,
    output logic            in_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       accept;

    assign accept   = (state_reg == ST_IDLE) && in_valid && status.advance;
    assign in_stall = !((state_reg == ST_IDLE) && status.advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && operation == OP_COMPARE && status.line_phase)
                begin
                    state_next = status.draw_ok ? ST_PIXELS : ST_WHITE;
                end
            end
            ST_PIXELS:
            begin
                if (status.advance && status.col_last)
                begin
                    state_next = ST_BLACK;
                end
            end
            ST_WHITE:
            begin
                if (status.advance)
                begin
                    state_next = ST_BLACK;
                end
            end
            ST_BLACK:
            begin
                if (status.advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.kind        = RES_TICK;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_WRITE:
                        begin
                            cmd.write_pixel = 1'b1;
                        end
                        OP_TICK:
                        begin
                            cmd.tick  = 1'b1;
                            cmd.issue = 1'b1;
                            cmd.kind  = RES_TICK;
                        end
                        OP_COMPARE:
                        begin
                            if (!status.line_phase)
                            begin
                                cmd.porch = 1'b1;
                                cmd.issue = 1'b1;
                                cmd.kind  = RES_PORCH;
                            end
                            else
                            begin
                                cmd.draw_start = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.issue = 1'b0;
                        end
                    endcase
                end
            end
            ST_PIXELS:
            begin
                cmd.issue = status.advance;
                cmd.kind  = RES_PIXEL;
            end
            ST_WHITE:
            begin
                cmd.issue = status.advance;
                cmd.kind  = RES_WHITE;
            end
            ST_BLACK:
            begin
                cmd.issue = status.advance;
                cmd.kind  = RES_BLACK;
            end
            default:
            begin
                cmd.issue = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/cvlg_datapath.sv
// Line state, config registers, frame store and the two-stage result pipeline.
`default_nettype none
module cvlg_datapath
    import cvlg_pkg::*;
#(
    parameter int LINE_PIXELS = DEF_LINE_PIXELS,
    parameter int FRAME_ROWS  = DEF_FRAME_ROWS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [2:0] cfg_index,
    input  wire logic [8:0] cfg_data,
    input  wire in_item_t   in_item,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      status,
    input  wire logic       out_stall,
    output logic            out_valid,
    output out_item_t       out_item
);

    localparam int DEPTH = FRAME_ROWS * LINE_PIXELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (LINE_PIXELS > 1) ? $clog2(LINE_PIXELS) : 1;
    localparam logic [8:0] ROWS9  = 9'(FRAME_ROWS);
    localparam logic [5:0] COLS6  = 6'(LINE_PIXELS);
    localparam logic [CW-1:0] COL_LAST = CW'(LINE_PIXELS - 1);

    // config registers
    logic [8:0] first_line_reg;
    logic       display_en_reg;
    logic       burst_en_reg;
    logic [7:0] burst_level_reg;
    logic [7:0] white_level_reg;
    logic [7:0] black_level_reg;

    // line state
    logic [8:0] scan_line_reg;
    logic [8:0] scan_line_next;
    logic [7:0] display_row_reg;
    logic [7:0] display_row_next;
    logic       draw_allowed_reg;
    logic       draw_allowed_next;
    logic       vsync_reg;
    logic       vsync_next;
    logic       phase_reg;

    // draw addressing
    logic [CW-1:0] col_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [AW-1:0] wr_addr;
    logic          wr_in_range;
    logic          row_in_range;

    logic [7:0] frame_mem [DEPTH];
    logic [7:0] rd_data_reg;

    logic       advance;
    logic       s1_valid_reg;
    logic       s1_from_mem_reg;
    out_item_t  s1_item_reg;
    out_item_t  s1_item_next;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    out_item_t  out_item_next;

    assign advance      = !out_valid_reg || !out_stall;
    assign row_in_range = {1'b0, display_row_reg} < ROWS9;
    assign wr_in_range  = ({3'b000, in_item.pixel_row} < ROWS9)
                       && ({1'b0, in_item.pixel_col} < COLS6);
    assign wr_addr      = AW'(in_item.pixel_row) * AW'(LINE_PIXELS) + AW'(in_item.pixel_col);

    assign status.advance    = advance;
    assign status.line_phase = phase_reg;
    assign status.draw_ok    = draw_allowed_reg && row_in_range;
    assign status.col_last   = (col_reg == COL_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_line_reg  <= 9'd40;
            display_en_reg  <= 1'b1;
            burst_en_reg    <= 1'b1;
            burst_level_reg <= 8'd85;
            white_level_reg <= 8'd255;
            black_level_reg <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FIRST_DRAWN_LINE: first_line_reg  <= cfg_data;
                REG_DISPLAY_ENABLE:   display_en_reg  <= cfg_data[0];
                REG_BURST_ENABLE:     burst_en_reg    <= cfg_data[0];
                REG_BURST_LEVEL:      burst_level_reg <= cfg_data[7:0];
                REG_WHITE_LEVEL:      white_level_reg <= cfg_data[7:0];
                REG_BLACK_LEVEL:      black_level_reg <= cfg_data[7:0];
                default:              first_line_reg  <= first_line_reg;
            endcase
        end
    end

    // line tick: the row limit check sees the advanced row, the fixed-line
    // checks then override
    always_comb
    begin
        scan_line_next = scan_line_reg + 9'd1;
        if (scan_line_next > LINE_WRAP)
        begin
            scan_line_next = 9'd0;
        end
        display_row_next = display_row_reg;
        if (scan_line_next > first_line_reg)
        begin
            display_row_next = display_row_reg + {7'd0, scan_line_next[0]};
        end
        draw_allowed_next = draw_allowed_reg;
        if ({1'b0, display_row_next} >= ROWS9)
        begin
            draw_allowed_next = 1'b0;
        end
        if (scan_line_next == ROW_RESET_LINE)
        begin
            display_row_next = 8'd0;
        end
        if (scan_line_next == first_line_reg)
        begin
            draw_allowed_next = display_en_reg;
        end
        vsync_next = vsync_reg;
        if (scan_line_next == VSYNC_ON_LINE)
        begin
            vsync_next = 1'b1;
        end
        if (scan_line_next == VSYNC_OFF_LINE)
        begin
            vsync_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_line_reg    <= 9'd0;
            display_row_reg  <= 8'd0;
            draw_allowed_reg <= 1'b0;
            vsync_reg        <= 1'b0;
            phase_reg        <= 1'b0;
        end
        else if (cmd.tick)
        begin
            scan_line_reg    <= scan_line_next;
            display_row_reg  <= display_row_next;
            draw_allowed_reg <= draw_allowed_next;
            vsync_reg        <= vsync_next;
            phase_reg        <= 1'b0;
        end
        else if (cmd.porch)
        begin
            phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            rd_addr_reg <= '0;
        end
        else if (cmd.draw_start)
        begin
            col_reg     <= '0;
            rd_addr_reg <= AW'(display_row_reg) * AW'(LINE_PIXELS);
        end
        else if (cmd.issue && cmd.kind == RES_PIXEL)
        begin
            col_reg     <= col_reg + CW'(1);
            rd_addr_reg <= rd_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_pixel && wr_in_range)
        begin
            frame_mem[wr_addr] <= in_item.pixel_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue && cmd.kind == RES_PIXEL)
        begin
            rd_data_reg <= frame_mem[rd_addr_reg];
        end
    end

    always_comb
    begin
        s1_item_next              = '0;
        s1_item_next.sync_drive   = vsync_reg;
        s1_item_next.video_update = 1'b1;
        case (cmd.kind)
            RES_TICK:
            begin
                s1_item_next.sync_drive   = !vsync_next;
                s1_item_next.video_update = 1'b0;
                s1_item_next.last         = 1'b1;
            end
            RES_PORCH:
            begin
                s1_item_next.video_update = burst_en_reg && draw_allowed_reg;
                s1_item_next.video_level  = (burst_en_reg && draw_allowed_reg)
                                          ? burst_level_reg : 8'd0;
                s1_item_next.last         = 1'b1;
            end
            RES_PIXEL:
            begin
                s1_item_next.last = 1'b0;
            end
            RES_WHITE:
            begin
                s1_item_next.video_level = white_level_reg;
            end
            RES_BLACK:
            begin
                s1_item_next.video_level = black_level_reg;
                s1_item_next.last        = 1'b1;
            end
            default:
            begin
                s1_item_next.last = 1'b0;
            end
        endcase
    end

    // pixel results take their level from the frame store read
    always_comb
    begin
        out_item_next = s1_item_reg;
        if (s1_from_mem_reg)
        begin
            out_item_next.video_level = rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= cmd.issue;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg     <= s1_item_next;
            s1_from_mem_reg <= (cmd.kind == RES_PIXEL);
            out_item_reg    <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire

FILE: rtl/composite_video_line_generator_core.sv
// Top level of the composite video line generator.
// An issued result passes the first result register and then the output register
// before it reaches out_item. Pixel writes, line ticks and porch compares are each
// one item; a drawn line steps through accept, one pixel per column from the frame
// store's single read port, then black; a white line through accept, white, black.
// Reset (rst_n, async, active low) restores config defaults and clears line state;
// the frame store is not cleared.
`default_nettype none
module composite_video_line_generator_core
    import cvlg_pkg::*;
#(
    parameter int LINE_PIXELS = DEF_LINE_PIXELS,
    parameter int FRAME_ROWS  = DEF_FRAME_ROWS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [2:0] cfg_index,
    input  wire logic [8:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_item_t   in_item,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_item
);

    dp_cmd_t    cmd;
    dp_status_t status;

    cvlg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (in_item.operation),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    cvlg_datapath #(
        .LINE_PIXELS (LINE_PIXELS),
        .FRAME_ROWS  (FRAME_ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

FILE: rtl/cvlg_checker.sv
// Port-level checks for the composite video line generator, bound to the top level.
`default_nettype none
module cvlg_checker
    import cvlg_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_item_t  in_item,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_item
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result item changed while stalled");

    // results without a new video level only come from ticks and porch
    // compares, which give a single result
    a_noupd_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.video_update |-> out_item.last)
        else $error("non-update result is not last");

    a_noupd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.video_update |-> out_item.video_level == 8'd0)
        else $error("non-update result carries a level");

    // an empty output with the input stalled means a line is being issued
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall && !out_valid |=> out_valid || in_stall)
        else $error("input stalled with nothing pending");

endmodule

bind composite_video_line_generator_core cvlg_checker u_cvlg_checker (.*);
`default_nettype wire
